// File: design/dis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval set package
// Shared sizes, status codes, word types and controller/datapath links.
// ----------------------------------------------------------------------------
package dis_pkg;

    localparam int MaxIntervals = 64;
    localparam int ValueBits    = 16;
    localparam int CountBits    = $clog2(MaxIntervals + 1);

    localparam logic       OP_ADD  = 1'b0;
    localparam logic       OP_LIST = 1'b1;

    localparam logic [2:0] ST_LISTED  = 3'd0;
    localparam logic [2:0] ST_ADDED   = 3'd1;
    localparam logic [2:0] ST_COVERED = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_LIST
    } t_state;

    typedef struct packed {
        logic                 operation;
        logic [ValueBits-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [ValueBits-1:0] range_start;
        logic [ValueBits-1:0] range_end;
        logic [2:0]           status;
        logic                 last;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic upd;
        logic list_step;
        logic list_empty;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic list_done;
    } t_stat;

endpackage

// File: design/disjoint_interval_set_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint interval set
// Sorted table of up to 64 disjoint closed intervals with add and list.
// ----------------------------------------------------------------------------
// An add word passes through a compare step, which checks the value against
// every stored interval at once, then an update step, which extends, merges,
// or opens a space in the cell chain by a single shift, with the status loaded
// into the output register in the same cycle as the update. busy drops as the
// result appears; no new word is taken while an add is in progress. A list
// word streams one interval per cycle, through the list state and the output
// register, by rotating the cell chain so cell 0 presents each in turn; an
// empty table gives one empty marker in the cycle after acceptance
// without raising busy. busy is high while a word is in progress; results are
// strobed by o_valid for one cycle each and are not held, so the receiver must
// take every one as it appears.
// ----------------------------------------------------------------------------
module disjoint_interval_set_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  dis_pkg::t_in_word  i_word,
    output logic               busy,
    output logic               o_valid,
    output dis_pkg::t_out_word o_word
);

    dis_pkg::t_cmd  cmd;
    dis_pkg::t_stat stat;

    // sequence the steps of each word
    dis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_word.operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    // hold the interval cells and the result register
    dis_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (i_word.value),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

    // an add result follows its update step
    a_add_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.upd |=> o_valid && o_word.last)
        else $error("add result missing");

    // a list on an empty table answers at once with the empty marker
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.list_empty |=> o_valid && o_word.status == dis_pkg::ST_EMPTY)
        else $error("empty marker missing");

    // an accepted add keeps the block busy for the compare step
    a_add_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_word.operation == dis_pkg::OP_ADD |=> busy && !o_valid)
        else $error("add not sequenced");

endmodule

// File: design/dis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval set controller
// Sequences compare, update and listing steps of the datapath.
// ----------------------------------------------------------------------------
module dis_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_operation,
    input  dis_pkg::t_stat i_stat,
    output dis_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    dis_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dis_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dis_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_operation == dis_pkg::OP_ADD) begin
                        n_state = dis_pkg::S_CMP;
                    end else if (!i_stat.count_zero) begin
                        n_state = dis_pkg::S_LIST;
                    end
                end
            end
            dis_pkg::S_CMP: n_state = dis_pkg::S_UPD;
            dis_pkg::S_UPD: n_state = dis_pkg::S_IDLE;
            dis_pkg::S_LIST: begin
                if (i_stat.list_done) begin
                    n_state = dis_pkg::S_IDLE;
                end
            end
            default: n_state = dis_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            dis_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start && (i_operation == dis_pkg::OP_ADD);
                o_cmd.list_empty = i_start && (i_operation == dis_pkg::OP_LIST)
                                   && i_stat.count_zero;
            end
            dis_pkg::S_CMP:  o_cmd = '0;
            dis_pkg::S_UPD:  o_cmd.upd = 1'b1;
            dis_pkg::S_LIST: o_cmd.list_step = 1'b1;
            default:         o_cmd = '0;
        endcase
    end

endmodule

// File: design/dis_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval set datapath
// Chain of interval cells with per-cell compare, shift and rotate.
// ----------------------------------------------------------------------------
module dis_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [dis_pkg::ValueBits-1:0]     i_value,
    input  dis_pkg::t_cmd                     i_cmd,
    output dis_pkg::t_stat                    o_stat,
    output logic                              o_valid,
    output dis_pkg::t_out_word                o_word
);

    localparam int N = dis_pkg::MaxIntervals;
    localparam int W = dis_pkg::ValueBits;
    localparam int C = dis_pkg::CountBits;

    logic [W-1:0] r_start [N];
    logic [W-1:0] r_end   [N];
    logic [N-1:0] r_le;
    logic [W-1:0] r_v;
    logic [C-1:0] r_cnt;
    logic [C-1:0] r_lidx;
    logic         r_valid;
    dis_pkg::t_out_word r_out;

    logic [N-1:0] valid, le, f_sel, b_sel;
    logic [W-1:0] front_end, behind_start;
    logic         has_front, has_behind, covered, jf, jb, full, lst;

    // per-cell compare, registered for the update step
    always_comb begin
        for (int i = 0; i < N; i++) begin
            valid[i] = C'(i) < r_cnt;
            le[i]    = valid[i] && (r_start[i] <= r_v);
        end
    end

    // locate front (last start <= v) and behind (first start > v) cells
    always_comb begin
        front_end    = '0;
        behind_start = '0;
        for (int i = 0; i < N; i++) begin
            f_sel[i] = r_le[i] && ((i == N - 1) ? 1'b1 : !r_le[(i + 1) % N]);
            b_sel[i] = !r_le[i] && ((i == 0) ? 1'b1 : r_le[(i + N - 1) % N]);
            if (f_sel[i]) front_end = front_end | r_end[i];
            if (b_sel[i] && valid[i]) behind_start = behind_start | r_start[i];
        end
        has_front  = r_le[0];
        has_behind = |(b_sel & valid);
        covered    = has_front && (r_v <= front_end);
        jf = has_front && (({1'b0, front_end} + (W+1)'(1)) == {1'b0, r_v});
        jb = has_behind && ({1'b0, behind_start} == ({1'b0, r_v} + (W+1)'(1)));
        full = r_cnt == C'(N);
        lst  = r_lidx == (r_cnt - C'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v <= i_value;
        end
        r_le <= le;
        for (int i = 0; i < N; i++) begin
            if (i_cmd.upd && !covered) begin
                if (jf && jb) begin
                    if (f_sel[i] && i < N - 1) r_end[i] <= r_end[(i + 1) % N];
                    if (!r_le[i] && i < N - 1) begin
                        r_start[i] <= r_start[(i + 1) % N];
                        r_end[i]   <= r_end[(i + 1) % N];
                    end
                end else if (jf) begin
                    if (f_sel[i]) r_end[i] <= r_v;
                end else if (jb) begin
                    if (b_sel[i]) r_start[i] <= r_v;
                end else if (!full) begin
                    if (b_sel[i]) begin
                        r_start[i] <= r_v;
                        r_end[i]   <= r_v;
                    end else if (!r_le[i] && i > 0) begin
                        r_start[i] <= r_start[(i + N - 1) % N];
                        r_end[i]   <= r_end[(i + N - 1) % N];
                    end
                end
            end else if (i_cmd.list_step) begin
                // rotate the stored intervals so cell 0 presents the next one
                if (C'(i + 1) < r_cnt) begin
                    r_start[i] <= r_start[(i + 1) % N];
                    r_end[i]   <= r_end[(i + 1) % N];
                end else if (C'(i + 1) == r_cnt) begin
                    r_start[i] <= r_start[0];
                    r_end[i]   <= r_end[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_lidx  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.upd || i_cmd.list_step || i_cmd.list_empty;
            if (i_cmd.upd && !covered) begin
                if (jf && jb) begin
                    r_cnt <= r_cnt - C'(1);
                end else if (!jf && !jb && !full) begin
                    r_cnt <= r_cnt + C'(1);
                end
            end
            if (i_cmd.list_step) begin
                r_lidx <= lst ? '0 : r_lidx + C'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.list_step) begin
            r_out.range_start <= r_start[0];
            r_out.range_end   <= r_end[0];
            r_out.status      <= dis_pkg::ST_LISTED;
            r_out.last        <= lst;
        end else begin
            r_out.range_start <= '0;
            r_out.range_end   <= '0;
            r_out.last        <= 1'b1;
            if (i_cmd.list_empty) r_out.status <= dis_pkg::ST_EMPTY;
            else if (covered)     r_out.status <= dis_pkg::ST_COVERED;
            else if (jf || jb || !full) r_out.status <= dis_pkg::ST_ADDED;
            else                  r_out.status <= dis_pkg::ST_FULL;
        end
    end

    assign o_stat.count_zero = r_cnt == '0;
    assign o_stat.list_done  = lst;
    assign o_valid = r_valid;
    assign o_word  = r_out;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval set testbench
// Drives add and list words through the command handshake and checks every
// strobed result against a local model of the sorted interval table.
// ----------------------------------------------------------------------------
module tb_top;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    dis_pkg::t_in_word  i_word;
    logic               busy;
    logic               o_valid;
    dis_pkg::t_out_word o_word;

    disjoint_interval_set_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_word  (i_word),
        .busy    (busy),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

    // Local copy of the interval table.
    logic [dis_pkg::ValueBits-1:0] lo_tab [dis_pkg::MaxIntervals];
    logic [dis_pkg::ValueBits-1:0] hi_tab [dis_pkg::MaxIntervals];
    int                            n_held;

    dis_pkg::t_in_word  pending_words [$];
    dis_pkg::t_out_word expected_words [$];
    int                 idle_pct;
    bit                 failed;
    logic               busy_at_rise;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Insert one value into the table and return the status code.
    function automatic logic [2:0] insert_value(input logic [dis_pkg::ValueBits-1:0] v);
        int  p;
        bit  join_lo;
        bit  join_hi;
        p = 0;
        while (p < n_held && lo_tab[p] <= v) p++;
        if (p > 0 && v <= hi_tab[p-1]) return dis_pkg::ST_COVERED;
        join_lo = (p > 0) && ({1'b0, hi_tab[p-1]} + 17'd1 == {1'b0, v});
        join_hi = (p < n_held) && ({1'b0, lo_tab[p]} == {1'b0, v} + 17'd1);
        if (join_lo && join_hi) begin
            hi_tab[p-1] = hi_tab[p];
            for (int i = p; i + 1 < n_held; i++) begin
                lo_tab[i] = lo_tab[i+1];
                hi_tab[i] = hi_tab[i+1];
            end
            n_held--;
            return dis_pkg::ST_ADDED;
        end
        if (join_lo) begin
            hi_tab[p-1] = v;
            return dis_pkg::ST_ADDED;
        end
        if (join_hi) begin
            lo_tab[p] = v;
            return dis_pkg::ST_ADDED;
        end
        if (n_held >= dis_pkg::MaxIntervals) return dis_pkg::ST_FULL;
        for (int i = n_held; i > p; i--) begin
            lo_tab[i] = lo_tab[i-1];
            hi_tab[i] = hi_tab[i-1];
        end
        lo_tab[p] = v;
        hi_tab[p] = v;
        n_held++;
        return dis_pkg::ST_ADDED;
    endfunction

    // Work out the results one accepted word causes and queue them.
    function automatic void predict_word(input dis_pkg::t_in_word w);
        dis_pkg::t_out_word r;
        r = '0;
        r.last = 1'b1;
        if (w.operation == dis_pkg::OP_ADD) begin
            r.status = insert_value(w.value);
            expected_words = {expected_words, r};
        end else if (n_held == 0) begin
            r.status = dis_pkg::ST_EMPTY;
            expected_words = {expected_words, r};
        end else begin
            for (int i = 0; i < n_held; i++) begin
                r.range_start = lo_tab[i];
                r.range_end   = hi_tab[i];
                r.status      = dis_pkg::ST_LISTED;
                r.last        = (i + 1 == n_held);
                expected_words = {expected_words, r};
            end
        end
    endfunction

    // busy as seen at the last rising edge decides acceptance there.
    always @(posedge i_clk) busy_at_rise <= busy;

    // Driver: change inputs at the falling edge; predict on acceptance.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy_at_rise) predict_word(i_word);
            if ((start && !busy_at_rise) || !start) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_word <= pending_words.pop_front();
                    start  <= 1'b1;
                end else begin
                    start  <= 1'b0;
                    i_word <= ($bits(dis_pkg::t_in_word))'($urandom);
                end
            end
        end
    end

    // Monitor: sample results at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, o_word);
                failed = 1'b1;
            end else begin
                dis_pkg::t_out_word exp_w;
                exp_w = expected_words.pop_front();
                if (exp_w !== o_word) begin
                    $display("%0t: mismatch expected %p actual %p", $realtime, exp_w, o_word);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic queue_word(input logic op, input logic [dis_pkg::ValueBits-1:0] v);
        dis_pkg::t_in_word w;
        w.operation = op;
        w.value     = v;
        pending_words = {pending_words, w};
    endtask

    // Drain: hold until every pending word is taken and every result is back.
    task automatic drain();
        while (pending_words.size() > 0 || start || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [dis_pkg::ValueBits-1:0] base;
        int                            k;
        failed    = 1'b0;
        n_held    = 0;
        idle_pct  = 0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_word    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty list, both ends of the range, covered, merges.
        queue_word(dis_pkg::OP_LIST, 16'hFFFF);
        queue_word(dis_pkg::OP_ADD, 16'h0000);
        queue_word(dis_pkg::OP_ADD, 16'hFFFF);
        queue_word(dis_pkg::OP_ADD, 16'hFFFF);
        queue_word(dis_pkg::OP_ADD, 16'hFFFE);
        queue_word(dis_pkg::OP_ADD, 16'h0002);
        queue_word(dis_pkg::OP_ADD, 16'h0001);
        queue_word(dis_pkg::OP_ADD, 16'h5555);
        queue_word(dis_pkg::OP_ADD, 16'hAAAA);
        queue_word(dis_pkg::OP_ADD, 16'h5556);
        queue_word(dis_pkg::OP_ADD, 16'h0001);
        queue_word(dis_pkg::OP_LIST, 16'h0000);
        drain();

        // Fill the table with isolated values, then hit it while full.
        for (int i = 0; i < dis_pkg::MaxIntervals; i++)
            queue_word(dis_pkg::OP_ADD, 16'(1000 + 4 * i));
        queue_word(dis_pkg::OP_ADD, 16'd7);
        queue_word(dis_pkg::OP_ADD, 16'd1001);
        queue_word(dis_pkg::OP_ADD, 16'd1002);
        queue_word(dis_pkg::OP_LIST, 16'h1234);
        drain();

        // Random phases: no idling, heavy sender gaps, medium gaps.
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 83 : 29;
            base = 16'($urandom);
            for (k = 0; k < 120; k++) begin
                if ($urandom_range(9) == 0)
                    queue_word(dis_pkg::OP_LIST, 16'($urandom));
                else if ($urandom_range(9) == 0)
                    queue_word(dis_pkg::OP_ADD, 16'($urandom));
                else
                    // Cluster around a base so extends and merges are common.
                    queue_word(dis_pkg::OP_ADD, base + 16'($urandom_range(200)));
            end
            queue_word(dis_pkg::OP_LIST, 16'h0);
            drain();
        end

        if (!failed && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
